>>> src/btf_pkg.sv
// ----------------------------------------------------------------------------
// btf_pkg: shared types and constants of the bicubic texel filter
// Weight format, texel packing, cubic coefficients and the channel rounding
// and clamping used by every blend lane.
// ----------------------------------------------------------------------------
package btf_pkg;

  localparam int FRAC_W   = 16;
  localparam int WGT_W    = 18;   // signed 2.16 weight, |w| < 1.0
  localparam int NUM_W    = 57;   // exact numerator of one weight polynomial
  localparam int MAG_W    = 22;   // |numerator| >> 32
  localparam int Q_W      = 18;   // quotient estimate width
  localparam int RECIP_SH = 26;
  localparam int DIV_C    = 18;
  localparam int SUM_W    = 32;   // per-channel 16.16 sum
  localparam int ROUND_HALF = 32768;
  localparam int WGT_LAT  = 6;    // weight generator latency
  localparam int BLEND_LAT = 2;   // blend lane latency

  // floor(2^26 / 18); the estimate is at most one below the true quotient.
  localparam logic [MAG_W-1:0] RECIP = MAG_W'((1 << RECIP_SH) / DIV_C);

  // Mitchell-Netravali polynomials in units of 1/18, constant term first.
  localparam int POLY [4][4] = '{
    '{  1, -9,  15,  -7 },
    '{ 16,  0, -36,  21 },
    '{  1,  9,  27, -21 },
    '{  0,  0,  -6,   7 }
  };

  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef wgt_t [3:0] wgt_vec_t;
  typedef logic [31:0] texel_t;
  typedef texel_t [3:0] texel_row_t;
  typedef logic [63:0] texel_pair_t;
  typedef logic [FRAC_W-1:0] frac_t;

  // floor((sum + 32768) / 65536), then clamp to 0..maxv.
  function automatic logic [7:0] round_clamp(input logic signed [SUM_W-1:0] sum,
                                             input logic [7:0] maxv);
    logic signed [SUM_W-1:0] v;
    logic signed [SUM_W-1:0] lim;
    logic [7:0] res;
    v   = (sum + signed'(SUM_W'(ROUND_HALF))) >>> 16;
    lim = signed'(SUM_W'(maxv));
    if (v < 0) begin
      res = 8'd0;
    end else if (v > lim) begin
      res = maxv;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

>>> src/btf_weight.sv
// ----------------------------------------------------------------------------
// btf_weight: cubic weight generator
// Turns one 0.16 fraction into four signed 2.16 weights, truncated toward
// zero, over a six-stage pipeline.
// ----------------------------------------------------------------------------
module btf_weight (
  input  logic              clk,
  input  btf_pkg::frac_t    frac,
  output btf_pkg::wgt_vec_t wgt
);
  import btf_pkg::*;

  frac_t                    f1, f2_f;
  logic [2*FRAC_W-1:0]      sq1, sq2;
  logic [3*FRAC_W-1:0]      cube2;
  logic signed [NUM_W-1:0]  num3 [4];
  logic signed [NUM_W-1:0]  num_next [4];
  logic [MAG_W-1:0]         mag4 [4], mag5 [4];
  logic                     neg4 [4], neg5 [4];
  logic [Q_W-1:0]           q05 [4];

  // Stage 1: square. Stage 2: cube.
  always_ff @(posedge clk) begin
    f1    <= frac;
    sq1   <= (2*FRAC_W)'(frac) * (2*FRAC_W)'(frac);
    f2_f  <= f1;
    sq2   <= sq1;
    cube2 <= (3*FRAC_W)'(sq1) * (3*FRAC_W)'(f1);
  end

  // Stage 3: exact numerator c0*2^48 + c1*f*2^32 + c2*f^2*2^16 + c3*f^3.
  always_comb begin
    logic signed [NUM_W-1:0] tf, tf2, tf3;
    tf  = signed'(NUM_W'({f2_f, 32'b0}));
    tf2 = signed'(NUM_W'({sq2, 16'b0}));
    tf3 = signed'(NUM_W'(cube2));
    for (int i = 0; i < 4; i++) begin
      num_next[i] = (NUM_W'(POLY[i][0]) <<< 48)
                  + NUM_W'(POLY[i][1]) * tf
                  + NUM_W'(POLY[i][2]) * tf2
                  + NUM_W'(POLY[i][3]) * tf3;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      num3[i] <= num_next[i];
    end
  end

  // Stage 4: magnitude scaled by 2^-32. Stage 5: reciprocal estimate of /18.
  always_ff @(posedge clk) begin
    logic signed [NUM_W-1:0] absn;
    logic [2*MAG_W-1:0]      prod;
    for (int i = 0; i < 4; i++) begin
      absn    = num3[i][NUM_W-1] ? -num3[i] : num3[i];
      neg4[i] <= num3[i][NUM_W-1];
      mag4[i] <= absn[MAG_W+31:32];
      prod    = (2*MAG_W)'(mag4[i]) * (2*MAG_W)'(RECIP);
      q05[i]  <= prod[RECIP_SH+Q_W-1:RECIP_SH];
      mag5[i] <= mag4[i];
      neg5[i] <= neg4[i];
    end
  end

  // Stage 6: one correction step, then restore the sign.
  always_ff @(posedge clk) begin
    logic [MAG_W:0]  rem;
    logic [WGT_W-1:0] q;
    for (int i = 0; i < 4; i++) begin
      rem = (MAG_W+1)'(mag5[i]) - (MAG_W+1)'(q05[i]) * (MAG_W+1)'(DIV_C);
      q   = WGT_W'(q05[i] + Q_W'(rem >= (MAG_W+1)'(DIV_C)));
      wgt[i] <= neg5[i] ? -signed'(q) : signed'(q);
    end
  end

endmodule

>>> src/btf_blend.sv
// ----------------------------------------------------------------------------
// btf_blend: four-tap blend lane
// Weights four ARGB texels, rounds each channel and clamps alpha to 0..255
// and each colour to 0..alpha. Two pipeline stages.
// ----------------------------------------------------------------------------
module btf_blend (
  input  logic               clk,
  input  btf_pkg::wgt_vec_t  wgt,
  input  btf_pkg::texel_row_t px,
  output btf_pkg::texel_t    pixel
);
  import btf_pkg::*;

  localparam int PROD_W = WGT_W + 9;

  logic signed [PROD_W-1:0] prod [4][4];
  logic signed [SUM_W-1:0]  sum [4];
  logic [7:0]               a, r, g, b;

  // Stage 1: one product per tap and channel; channel 0 is alpha.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int c = 0; c < 4; c++) begin
        prod[i][c] <= wgt[i] * signed'({1'b0, px[i][31-8*c -: 8]});
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = SUM_W'(prod[0][c]) + SUM_W'(prod[1][c])
             + SUM_W'(prod[2][c]) + SUM_W'(prod[3][c]);
    end
    a = round_clamp(sum[0], 8'd255);
    r = round_clamp(sum[1], a);
    g = round_clamp(sum[2], a);
    b = round_clamp(sum[3], a);
  end

  // Stage 2: packed result.
  always_ff @(posedge clk) begin
    pixel <= {a, r, g, b};
  end

endmodule

>>> src/bicubic_texel_filter.sv
// ----------------------------------------------------------------------------
// bicubic_texel_filter: Mitchell-Netravali bicubic filter, ARGB8888
// Four row lanes blend horizontally; a merging lane blends the rows vertically.
//
//   channel  | direction | transfer marker      | contents
//   command  | in        | start && !busy       | row0..3 left/right, frac_x, frac_y
//   result   | out       | done (one cycle)     | pixel_out
//
// One item is taken every cycle; busy is always low. A result passes through
// the input register, 6 weight stages, 2 row-lane stages and 2 merge-lane
// stages, all fully pipelined.
// Synchronous reset clears only the valid pipeline; data registers are free.
// The receiver cannot stall, so nothing ever holds the pipeline.
// ----------------------------------------------------------------------------
module bicubic_texel_filter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  btf_pkg::texel_pair_t row0_left,
  input  btf_pkg::texel_pair_t row0_right,
  input  btf_pkg::texel_pair_t row1_left,
  input  btf_pkg::texel_pair_t row1_right,
  input  btf_pkg::texel_pair_t row2_left,
  input  btf_pkg::texel_pair_t row2_right,
  input  btf_pkg::texel_pair_t row3_left,
  input  btf_pkg::texel_pair_t row3_right,
  input  btf_pkg::frac_t       frac_x,
  input  btf_pkg::frac_t       frac_y,
  output logic                 done,
  output btf_pkg::texel_t      pixel_out
);
  import btf_pkg::*;

  localparam int LAT = 1 + WGT_LAT + 2 * BLEND_LAT;

  logic [LAT-1:0] vld;
  logic [LAT-1:0] vld_next;
  texel_row_t     tex_in [4];
  texel_row_t     tex_d [WGT_LAT][4];
  frac_t          fx, fy;
  wgt_vec_t       wx, wy;
  wgt_vec_t       wy_d [BLEND_LAT];
  texel_row_t     rows;

  assign busy = 1'b0;
  assign vld_next = {vld[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    tex_in[0] <= {row0_right, row0_left};
    tex_in[1] <= {row1_right, row1_left};
    tex_in[2] <= {row2_right, row2_left};
    tex_in[3] <= {row3_right, row3_left};
    fx <= frac_x;
    fy <= frac_y;
  end

  // Texels wait for the weights, and the vertical weights wait for the row lanes.
  always_ff @(posedge clk) begin
    for (int n = 0; n < 4; n++) begin
      tex_d[0][n] <= tex_in[n];
      for (int k = 1; k < WGT_LAT; k++) begin
        tex_d[k][n] <= tex_d[k-1][n];
      end
    end
    wy_d[0] <= wy;
    for (int k = 1; k < BLEND_LAT; k++) begin
      wy_d[k] <= wy_d[k-1];
    end
  end

  btf_weight u_wgt_x (.clk(clk), .frac(fx), .wgt(wx));
  btf_weight u_wgt_y (.clk(clk), .frac(fy), .wgt(wy));

  for (genvar n = 0; n < 4; n++) begin : g_row
    btf_blend u_row (
      .clk  (clk),
      .wgt  (wx),
      .px   (tex_d[WGT_LAT-1][n]),
      .pixel(rows[n])
    );
  end

  btf_blend u_merge (
    .clk  (clk),
    .wgt  (wy_d[BLEND_LAT-1]),
    .px   (rows),
    .pixel(pixel_out)
  );

  assign done = vld[LAT-1];

  // Checks.
  logic signed [WGT_W+1:0] wx_sum;
  assign wx_sum = (WGT_W+2)'(wx[0]) + (WGT_W+2)'(wx[1])
                + (WGT_W+2)'(wx[2]) + (WGT_W+2)'(wx[3]);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a start at the pipeline latency");

  a_colour_le_alpha: assert property (@(posedge clk) disable iff (rst)
    done |-> (pixel_out[23:16] <= pixel_out[31:24]) &&
             (pixel_out[15:8] <= pixel_out[31:24]) &&
             (pixel_out[7:0] <= pixel_out[31:24]))
    else $error("colour channel above alpha");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    vld[WGT_LAT] |-> (wx_sum >= 65532) && (wx_sum <= 65540))
    else $error("horizontal weights do not sum to one");

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule
